// ===== rtl/hgcd_pkg.sv =====
`default_nettype none
package hgcd_pkg;

  // Field widths of the channels and the configuration register.
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RADIUS_W = 24;
  localparam int DIST_W   = 34;

  // Internal number formats.
  localparam int BAM_W      = 32;  // binary angle, 2^32 per turn
  localparam int Q30_W      = 32;  // signed Q30 sine, cosine and products
  localparam int CW         = 34;  // CORDIC datapath width
  localparam int RAD_W      = 62;  // square root radicand
  localparam int ROOT_W     = 31;  // square root result
  localparam int ROOT_STEPS = 31;  // one result bit per stage
  localparam int ANG_W      = 31;  // asin angle, 0 to a quarter turn
  localparam int QUO_W      = 27;  // quotient of an angle by 45

  typedef logic signed [LAT_W-1:0] lat_t;
  typedef logic signed [LON_W-1:0] lon_t;
  typedef logic [RADIUS_W-1:0]     radius_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic [BAM_W-1:0]        bam_t;
  typedef logic signed [Q30_W-1:0] q30_t;
  typedef logic signed [CW-1:0]    cordic_t;

  localparam radius_t RADIUS_RESET = 24'd6371000;

  // Degrees to binary angle: floor(deg * 2^9 / 45) for a full turn and
  // floor(deg * 2^8 / 45) for half differences. An offset that is a multiple
  // of 45 and vanishes modulo 2^32 after scaling keeps the dividend positive.
  localparam logic [31:0] OFFSET_FULL = 32'd3019898880;  // 45 * 2^26
  localparam logic [31:0] OFFSET_HALF = 32'd754974720;   // 45 * 2^24
  localparam logic [31:0] RECIP_45    = 32'd3054198966;  // floor(2^37 / 45)
  localparam int          RECIP_SHIFT = 37;
  localparam logic [14:0] FRAC_RECIP  = 15'd23302;       // ceil(2^20 / 45)
  localparam logic [5:0]  DIV_45      = 6'd45;

  localparam cordic_t CORDIC_ONE  = 34'sd1073741824;
  localparam cordic_t CORDIC_HALF = 34'sd2147483648;
  localparam cordic_t CORDIC_GAIN = 34'sd652032874;

  localparam logic [RAD_W-1:0] ROOT_ONE_SQ = RAD_W'(1) << 60;

  localparam logic [30:0] PI_Q29   = 31'd1686629713;
  localparam dist_t       DIST_TOP = 34'd13493037705;

  // Binary angle of atan(2^-k).
  function automatic logic [31:0] atan_entry(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000000;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hgcd_point_if.sv =====
`default_nettype none
interface hgcd_point_if import hgcd_pkg::*; ;
  logic valid;
  logic ready;
  lat_t lat_a;
  lon_t lon_a;
  lat_t lat_b;
  lon_t lon_b;

  modport source(output valid, output lat_a, output lon_a, output lat_b, output lon_b,
                 input ready);
  modport sink(input valid, input lat_a, input lon_a, input lat_b, input lon_b,
               output ready);
endinterface
`default_nettype wire

// ===== rtl/hgcd_dist_if.sv =====
`default_nettype none
interface hgcd_dist_if import hgcd_pkg::*; ;
  logic  valid;
  logic  ready;
  dist_t distance;

  modport source(output valid, output distance, input ready);
  modport sink(input valid, input distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/hgcd_cordic_rot.sv =====
`default_nettype none
module hgcd_cordic_rot import hgcd_pkg::*; #(
  parameter int STEPS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire bam_t bam,
  output logic      out_valid,
  output q30_t      sin_q,
  output q30_t      cos_q
);

  cordic_t x_q [0:STEPS];
  cordic_t y_q [0:STEPS];
  cordic_t z_q [0:STEPS];
  logic    neg_q [0:STEPS];
  logic    v_q [0:STEPS];

  cordic_t z_raw;
  cordic_t z_fold;
  logic    neg_fold;

  // Fold the angle into [-quarter, quarter]; the far half flips both outputs.
  always_comb begin
    z_raw    = {{(CW-BAM_W){bam[BAM_W-1]}}, bam};
    z_fold   = z_raw;
    neg_fold = 1'b0;
    if (z_raw > CORDIC_ONE) begin
      z_fold   = z_raw - CORDIC_HALF;
      neg_fold = 1'b1;
    end else if (z_raw < -CORDIC_ONE) begin
      z_fold   = z_raw + CORDIC_HALF;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]   <= CORDIC_GAIN;
      y_q[0]   <= '0;
      z_q[0]   <= z_fold;
      neg_q[0] <= neg_fold;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cordic_t atan_w;
    cordic_t xs;
    cordic_t ys;
    assign atan_w = CW'(atan_entry(5'(i)));
    assign xs     = x_q[i] >>> i;
    assign ys     = y_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else if (en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - atan_w;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + atan_w;
        end
      end
    end
  end

  cordic_t x_fin;
  cordic_t y_fin;
  cordic_t x_clip;
  cordic_t y_clip;

  always_comb begin
    x_fin = neg_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
    y_fin = neg_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
    x_clip = x_fin;
    y_clip = y_fin;
    if (x_fin > CORDIC_ONE) begin
      x_clip = CORDIC_ONE;
    end else if (x_fin < -CORDIC_ONE) begin
      x_clip = -CORDIC_ONE;
    end
    if (y_fin > CORDIC_ONE) begin
      y_clip = CORDIC_ONE;
    end else if (y_fin < -CORDIC_ONE) begin
      y_clip = -CORDIC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= y_clip[Q30_W-1:0];
      cos_q <= x_clip[Q30_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hgcd_cordic_vec.sv =====
`default_nettype none
module hgcd_cordic_vec import hgcd_pkg::*; #(
  parameter int STEPS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ROOT_W-1:0] x_in,
  input  wire logic [ROOT_W-1:0] y_in,
  output logic                   out_valid,
  output logic [ANG_W-1:0]       angle
);

  cordic_t x_q [0:STEPS];
  cordic_t y_q [0:STEPS];
  cordic_t z_q [0:STEPS];
  logic    v_q [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= CW'(x_in);
      y_q[0] <= CW'(y_in);
      z_q[0] <= '0;
    end
  end

  // Drive y toward zero; the accumulated angle is atan2(y, x).
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cordic_t atan_w;
    cordic_t xs;
    cordic_t ys;
    assign atan_w = CW'(atan_entry(5'(i)));
    assign xs     = x_q[i] >>> i;
    assign ys     = y_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else if (en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + atan_w;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - atan_w;
        end
      end
    end
  end

  cordic_t z_clip;

  always_comb begin
    z_clip = z_q[STEPS];
    if (z_q[STEPS] < 0) begin
      z_clip = '0;
    end else if (z_q[STEPS] > CORDIC_ONE) begin
      z_clip = CORDIC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= z_clip[ANG_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hgcd_isqrt.sv =====
`default_nettype none
module hgcd_isqrt import hgcd_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [RAD_W-1:0]  radicand,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic [ROOT_W-1:0]      root,
  output logic [SIDE_W-1:0]      side_out
);

  // Restoring square root, one result bit per stage. The side word travels
  // alongside and holds the valid bit, so it is cleared by reset.
  logic [RAD_W-1:0]  n_q    [1:ROOT_STEPS];
  logic [RAD_W-1:0]  r_q    [1:ROOT_STEPS];
  logic [SIDE_W-1:0] side_q [1:ROOT_STEPS];

  for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_STEPS - 1 - s));
    logic [RAD_W-1:0]  n_cur;
    logic [RAD_W-1:0]  r_cur;
    logic [SIDE_W-1:0] side_cur;
    logic [RAD_W-1:0]  trial;

    if (s == 0) begin : g_first
      assign n_cur    = radicand;
      assign r_cur    = '0;
      assign side_cur = side_in;
    end else begin : g_next
      assign n_cur    = n_q[s];
      assign r_cur    = r_q[s];
      assign side_cur = side_q[s];
    end

    assign trial = r_cur + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[s+1] <= '0;
      end else if (en) begin
        side_q[s+1] <= side_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_cur >= trial) begin
          n_q[s+1] <= n_cur - trial;
          r_q[s+1] <= (r_cur >> 1) + BIT;
        end else begin
          n_q[s+1] <= n_cur;
          r_q[s+1] <= r_cur >> 1;
        end
      end
    end
  end

  assign root     = r_q[ROOT_STEPS][ROOT_W-1:0];
  assign side_out = side_q[ROOT_STEPS];

endmodule
`default_nettype wire

// ===== rtl/haversine_great_circle_distance.sv =====
// Haversine great-circle distance, fully pipelined.
// The points channel carries one transaction per pair of points: lat_a,
// lon_a, lat_b, lon_b in signed degrees with 20 fraction bits. The result
// channel returns one transaction per pair: the distance in radius units
// with 8 fraction bits, saturated at its top value. Both channels use a
// valid/ready handshake; a transaction moves when both are high.
// Unless the result channel stalls, a new pair can enter in every cycle,
// so throughput is one pair per clock. From acceptance to result valid a
// pair passes through three stages of degree to binary angle conversion,
// a rotation CORDIC of ITERATION_STEPS + 2 stages for the sines and
// cosines, three product stages, two 31-stage square roots with two stages
// between them, a vectoring CORDIC of ITERATION_STEPS + 2 stages for asin,
// and three stages that scale by the radius into the output register.
// The user must write the sphere radius through cfg_we/cfg_wdata only while
// the pipeline is empty; the block does not enforce it. Reset clears every
// valid bit and loads a radius of 6371000. When the receiver holds ready low
// with a result waiting, the whole pipeline freezes and points.ready drops
// in the same cycle; nothing is dropped or repeated; bubbles move as data do.
`default_nettype none
module haversine_great_circle_distance import hgcd_pkg::*; #(
  parameter int ITERATION_STEPS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire radius_t       cfg_wdata,
  hgcd_point_if.sink         points,
  hgcd_dist_if.source        result
);

  localparam int LANES = 4;  // half dlat, half dlon, lat_a, lat_b

  // The pipeline advances unless a finished result is waiting and ready is low.
  logic en;
  logic out_v;
  dist_t dist_q;

  assign en            = !out_v || result.ready;
  assign points.ready  = en;
  assign result.valid  = out_v;
  assign result.distance = dist_q;

  radius_t radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // Angle conversion, stage A: offset dividends and reciprocal multiply.
  logic [33:0] u_sum [0:LANES-1];

  always_comb begin
    u_sum[0] = 34'(points.lat_b) - 34'(points.lat_a) + 34'(OFFSET_HALF);
    u_sum[1] = 34'(points.lon_b) - 34'(points.lon_a) + 34'(OFFSET_HALF);
    u_sum[2] = 34'(points.lat_a) + 34'(OFFSET_FULL);
    u_sum[3] = 34'(points.lat_b) + 34'(OFFSET_FULL);
  end

  logic a_v, b_v, c_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (en) begin
      a_v <= points.valid;
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  bam_t angle_bam [0:LANES-1];
  logic [LANES-1:0] rot_v;
  q30_t sin_l [0:LANES-1];
  q30_t cos_l [0:LANES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // Half differences scale by 2^8 / 45, whole angles by 2^9 / 45.
    localparam int QSHIFT = (l < 2) ? 8 : 9;
    localparam int FSHIFT = (l < 2) ? 12 : 11;

    logic [31:0]      u_q;
    logic [63:0]      recip_prod;
    logic [QUO_W-1:0] qe_q;
    logic [32:0]      rem_full;
    logic [QUO_W-1:0] q_q;
    logic [5:0]       r_q;
    logic [19:0]      frac_prod;

    assign recip_prod = u_sum[l][31:0] * RECIP_45;

    always_ff @(posedge clk) begin
      if (en) begin
        u_q  <= u_sum[l][31:0];
        qe_q <= recip_prod[63:RECIP_SHIFT];
      end
    end

    // The estimate is low by at most one; one compare fixes it.
    assign rem_full = 33'(u_q) - 33'(qe_q) * 33'(DIV_45);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_full[6:0] >= 7'(DIV_45)) begin
          q_q <= qe_q + 1'b1;
          r_q <= 6'(rem_full[6:0] - 7'(DIV_45));
        end else begin
          q_q <= qe_q;
          r_q <= rem_full[5:0];
        end
      end
    end

    assign frac_prod = 20'(r_q) * 20'(FRAC_RECIP);

    always_ff @(posedge clk) begin
      if (en) begin
        angle_bam[l] <= BAM_W'({q_q, QSHIFT'(0)}) + BAM_W'(frac_prod >> FSHIFT);
      end
    end

    hgcd_cordic_rot #(
      .STEPS (ITERATION_STEPS)
    ) u_rot (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c_v),
      .bam       (angle_bam[l]),
      .out_valid (rot_v[l]),
      .sin_q     (sin_l[l]),
      .cos_q     (cos_l[l])
    );
  end

  // Products: sin^2(dlat/2) + cos(lat_a) * cos(lat_b) * sin^2(dlon/2).
  logic signed [63:0] p_cc, p_sn, p_sl, p_term;
  q30_t cc_q, sn2_q, sl2_q, term_q, sl2b_q;
  logic p1_v, p2_v, p3_v;

  assign p_cc = cos_l[2] * cos_l[3];
  assign p_sn = sin_l[1] * sin_l[1];
  assign p_sl = sin_l[0] * sin_l[0];

  always_ff @(posedge clk) begin
    if (en) begin
      cc_q  <= p_cc[61:30];
      sn2_q <= p_sn[61:30];
      sl2_q <= p_sl[61:30];
    end
  end

  assign p_term = cc_q * sn2_q;

  always_ff @(posedge clk) begin
    if (en) begin
      term_q <= p_term[61:30];
      sl2b_q <= sl2_q;
    end
  end

  logic signed [32:0] a_sum;
  logic [ROOT_W-1:0]  a_q;

  assign a_sum = 33'(sl2b_q) + 33'(term_q);

  // The haversine a is clamped to [0, 1].
  always_ff @(posedge clk) begin
    if (en) begin
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > 33'sd1073741824) begin
        a_q <= ROOT_W'(CORDIC_ONE);
      end else begin
        a_q <= a_sum[ROOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else if (en) begin
      p1_v <= &rot_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  // s = sqrt(a), then c = sqrt(1 - s^2), both Q30.
  logic [ROOT_W-1:0] s_root;
  logic              s_v;

  hgcd_isqrt #(
    .SIDE_W (1)
  ) u_sqrt_s (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .radicand ({1'b0, a_q, 30'b0}),
    .side_in  (p3_v),
    .root     (s_root),
    .side_out (s_v)
  );

  logic [RAD_W-1:0]  ss_q;
  logic [RAD_W-1:0]  nc_q;
  logic [ROOT_W-1:0] s1_q, s2_q;
  logic              m1_v, m2_v;

  always_ff @(posedge clk) begin
    if (en) begin
      ss_q <= RAD_W'(s_root) * RAD_W'(s_root);
      s1_q <= s_root;
      nc_q <= ROOT_ONE_SQ - ss_q;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (en) begin
      m1_v <= s_v;
      m2_v <= m1_v;
    end
  end

  logic [ROOT_W-1:0] c_root;
  logic [ROOT_W:0]   c_side;

  hgcd_isqrt #(
    .SIDE_W (ROOT_W + 1)
  ) u_sqrt_c (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .radicand (nc_q),
    .side_in  ({s2_q, m2_v}),
    .root     (c_root),
    .side_out (c_side)
  );

  // asin(s) as atan2(s, c).
  logic             ang_v;
  logic [ANG_W-1:0] ang;

  hgcd_cordic_vec #(
    .STEPS (ITERATION_STEPS)
  ) u_asin (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_side[0]),
    .x_in      (c_root),
    .y_in      (c_side[ROOT_W:1]),
    .out_valid (ang_v),
    .angle     (ang)
  );

  // Distance = R * angle * pi / 2^51, with the product split at bit 26.
  logic [54:0] t_q;
  logic [59:0] ph_q;
  logic [56:0] pl_full;
  logic [30:0] pl_q;
  logic [60:0] d_sum;
  logic [35:0] d_full;
  logic        d1_v, d2_v;

  always_ff @(posedge clk) begin
    if (en) begin
      t_q <= 55'(radius) * 55'(ang);
    end
  end

  assign pl_full = 57'(t_q[25:0]) * 57'(PI_Q29);

  always_ff @(posedge clk) begin
    if (en) begin
      ph_q <= 60'(t_q[54:26]) * 60'(PI_Q29);
      pl_q <= pl_full[56:26];
    end
  end

  assign d_sum  = 61'(ph_q) + 61'(pl_q);
  assign d_full = d_sum[60:25];

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_full > 36'(DIST_TOP)) begin
        dist_q <= DIST_TOP;
      end else begin
        dist_q <= d_full[DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v  <= 1'b0;
      d2_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      d1_v  <= ang_v;
      d2_v  <= d1_v;
      out_v <= d2_v;
    end
  end

endmodule
`default_nettype wire
